// ===== src/rfla_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rfla_pkg
// Shared types, status codes and controller states of the range allocator.
// ---------------------------------------------------------------------------
package rfla_pkg;

   localparam int DefMaxRanges = 16;
   localparam int DefValueWidth = 32;
   localparam int StatusWidth = 3;
   localparam int AllocWidth = 32;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 3'd0,
      ST_INVERTED = 3'd1,
      ST_OVERLAP  = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, clear scan
      logic scan_step;  // examine one entry
      logic decide;     // apply merge or alloc, set shift plan
      logic shift_step; // move one entry
      logic finish;     // write inserted entry after shift up
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic need_shift;
      logic shift_last;
      logic early;      // result known without table scan
   } stat_type;

endpackage
`default_nettype wire

// ===== src/rfla_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rfla_datapath
// Range table registers, scan comparator and shift logic.
// ---------------------------------------------------------------------------
module rfla_datapath #(
   parameter int MAX_RANGES = rfla_pkg::DefMaxRanges,
   parameter int VALUE_WIDTH = rfla_pkg::DefValueWidth
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rfla_pkg::cmd_type              cmd,
   output rfla_pkg::stat_type                  stat,
   input  wire logic                           in_type,
   input  wire logic [VALUE_WIDTH-1:0]         in_from,
   input  wire logic [VALUE_WIDTH-1:0]         in_to,
   output logic [rfla_pkg::StatusWidth-1:0]    res_status,
   output logic [rfla_pkg::AllocWidth-1:0]     res_value
);
   import rfla_pkg::*;

   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [VALUE_WIDTH-1:0] VTop = '1;

   logic [VALUE_WIDTH-1:0] starts_ff [MAX_RANGES];
   logic [VALUE_WIDTH-1:0] ends_ff [MAX_RANGES];
   logic [CW-1:0] used_ff, used_in;
   logic type_ff;
   logic [VALUE_WIDTH-1:0] lo_ff, hi_ff;
   logic [CW-1:0] idx_ff, pos_ff;
   logic pos_found_ff, overlap_ff;
   // shift plan: up (insert) or down (drop), from sidx to send
   logic up_ff;
   logic [CW-1:0] sidx_ff, send_ff;
   logic [StatusWidth-1:0] status_ff;
   logic [AllocWidth-1:0] value_ff;

   logic [IW-1:0] cur;
   logic [VALUE_WIDTH-1:0] cs, ce;
   assign cur = idx_ff[IW-1:0];
   assign cs = starts_ff[cur];
   assign ce = ends_ff[cur];

   // decision terms at the found position
   logic [CW-1:0] pos_eff;
   logic jp, jn;
   logic [IW-1:0] pp, pn;
   always_comb begin
      pos_eff = pos_found_ff ? pos_ff : used_ff;
      pp = IW'(pos_eff - CW'(1));
      pn = pos_eff[IW-1:0];
      jp = (pos_eff != '0) && (lo_ff != '0) && (ends_ff[pp] == lo_ff - 1'b1);
      jn = (pos_eff < used_ff) && (hi_ff != VTop) && (starts_ff[pn] == hi_ff + 1'b1);
   end

   always_comb begin
      stat.scan_last = (idx_ff + CW'(1) >= used_ff);
      stat.early = type_ff || (lo_ff > hi_ff) || (used_ff == '0);
      stat.need_shift = (sidx_ff != send_ff);
      stat.shift_last = up_ff ? (sidx_ff - CW'(1) <= send_ff)
                              : (sidx_ff + CW'(1) >= send_ff);
   end

   // shift source/destination
   logic [IW-1:0] sd, ss;
   always_comb begin
      sd = sidx_ff[IW-1:0];
      ss = up_ff ? IW'(sidx_ff - CW'(1)) : IW'(sidx_ff + CW'(1));
   end

   // outcome and shift plan of the decide step
   logic [StatusWidth-1:0] dec_status;
   logic [AllocWidth-1:0] dec_value;
   logic [CW-1:0] dec_sidx, dec_send;
   logic dec_up;
   always_comb begin
      dec_status = ST_OK;
      dec_value = '0;
      dec_sidx = '0;
      dec_send = '0;
      dec_up = 1'b0;
      if (type_ff) begin
         if (used_ff == '0) begin
            dec_status = ST_EMPTY;
         end else begin
            dec_value = AllocWidth'(starts_ff[0]);
            if (starts_ff[0] == ends_ff[0]) dec_send = used_ff - CW'(1);
         end
      end else if (lo_ff > hi_ff) begin
         dec_status = ST_INVERTED;
      end else if (overlap_ff) begin
         dec_status = ST_OVERLAP;
      end else if (jp && jn) begin
         dec_sidx = pos_eff;
         dec_send = used_ff - CW'(1);
      end else if (!jp && !jn) begin
         if (used_ff >= CW'(MAX_RANGES)) begin
            dec_status = ST_FULL;
         end else begin
            // new entry goes in after shifting up
            dec_up = 1'b1;
            dec_sidx = used_ff;
            dec_send = pos_eff;
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.decide) begin
         if (type_ff) begin
            if (used_ff != '0 && starts_ff[0] == ends_ff[0]) used_in = used_ff - CW'(1);
         end else if (lo_ff <= hi_ff && !overlap_ff) begin
            if (jp && jn) used_in = used_ff - CW'(1);
            else if (!jp && !jn && used_ff < CW'(MAX_RANGES)) used_in = used_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // request capture, scan, decide and shift
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= in_type;
         lo_ff <= in_from;
         hi_ff <= in_to;
         idx_ff <= '0;
         pos_found_ff <= 1'b0;
         overlap_ff <= 1'b0;
         sidx_ff <= '0;
         send_ff <= '0;
      end
      if (cmd.scan_step) begin
         if (lo_ff <= ce && hi_ff >= cs) overlap_ff <= 1'b1;
         if (!pos_found_ff && !(cs < lo_ff)) begin
            pos_found_ff <= 1'b1;
            pos_ff <= idx_ff;
         end
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.decide) begin
         status_ff <= dec_status;
         value_ff <= dec_value;
         sidx_ff <= dec_sidx;
         send_ff <= dec_send;
         up_ff <= dec_up;
         if (type_ff) begin
            if (used_ff != '0 && starts_ff[0] != ends_ff[0]) begin
               starts_ff[0] <= starts_ff[0] + 1'b1;
            end
         end else if (lo_ff <= hi_ff && !overlap_ff) begin
            if (jp && jn) ends_ff[pp] <= ends_ff[pn];
            else if (jp) ends_ff[pp] <= hi_ff;
            else if (jn) starts_ff[pn] <= lo_ff;
         end
      end
      if (cmd.shift_step) begin
         starts_ff[sd] <= starts_ff[ss];
         ends_ff[sd] <= ends_ff[ss];
         sidx_ff <= up_ff ? sidx_ff - CW'(1) : sidx_ff + CW'(1);
      end
      if (cmd.finish && up_ff) begin
         starts_ff[send_ff[IW-1:0]] <= lo_ff;
         ends_ff[send_ff[IW-1:0]] <= hi_ff;
         up_ff <= 1'b0;
      end
   end

   assign res_status = status_ff;
   assign res_value = value_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_RANGES)) else $error("range count beyond table depth");
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_step |-> sidx_ff < CW'(MAX_RANGES)) else $error("shift index out of table");
   a_decide_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> !(cmd.load || cmd.scan_step || cmd.shift_step))
      else $error("decide overlaps another command");

endmodule
`default_nettype wire

// ===== src/rfla_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rfla_ctrl
// Sequencer and handshake of the range allocator.
// ---------------------------------------------------------------------------
module rfla_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rfla_pkg::cmd_type       cmd,
   input  wire rfla_pkg::stat_type stat
);
   import rfla_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SCAN;
         S_SCAN:   if (stat.early || stat.scan_last) state_in = S_DECIDE;
         S_DECIDE: state_in = S_SHIFT;
         S_SHIFT:  if (!stat.need_shift || stat.shift_last) state_in = S_DONE;
         S_DONE:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE:   begin req_ready = 1'b1; cmd.load = req_valid; end
         S_SCAN:   cmd.scan_step = !stat.early;
         S_DECIDE: cmd.decide = 1'b1;
         S_SHIFT:  begin
            cmd.shift_step = stat.need_shift;
            cmd.finish = !stat.need_shift || stat.shift_last;
         end
         S_DONE:   rsp_valid = 1'b1;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready and valid together");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

endmodule
`default_nettype wire

// ===== src/range_free_list_allocator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// range_free_list_allocator
// Sorted table of free value ranges with free and allocate requests.
// ---------------------------------------------------------------------------
// usage
// - req channel: req_type 0 frees range_from..range_to, 1 allocates lowest
// - rsp channel: one transaction per request, rsp_status and rsp_alloc_value
// - one request at a time: capture, scan of used entries (one per cycle),
//   decide, shift of the table (one entry per cycle), then result
// - rsp_valid rises in the done state, after the scan, decide and shift
//   states; the scan covers the used entries and the shift the moved ones
// - next request taken in the idle state, entered from the done state once
//   rsp_ready is high
// - allocate, inverted-range and empty-table requests skip the scan
// - reset empties the table, no clearing pass
// - a stalled result holds the block; no new request is taken meanwhile
module range_free_list_allocator #(
   parameter int MAX_RANGES = rfla_pkg::DefMaxRanges,
   parameter int VALUE_WIDTH = rfla_pkg::DefValueWidth
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_type,
   input  wire logic [31:0]                 req_range_from,
   input  wire logic [31:0]                 req_range_to,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [rfla_pkg::StatusWidth-1:0] rsp_status,
   output logic [31:0]                      rsp_alloc_value
);
   import rfla_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [VALUE_WIDTH-1:0] from_v, to_v;

   // operands taken modulo value width
   always_comb begin
      from_v = VALUE_WIDTH'({32'd0, req_range_from});
      to_v = VALUE_WIDTH'({32'd0, req_range_to});
   end

   rfla_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd, .stat
   );

   rfla_datapath #(.MAX_RANGES(MAX_RANGES), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock, .reset, .cmd, .stat,
      .in_type(req_type), .in_from(from_v), .in_to(to_v),
      .res_status(rsp_status), .res_value(rsp_alloc_value)
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the range allocator: a behavioural table model
// predicts status and handed-out value for every request, a monitor
// compares each response transaction in order, both sides idle at random.
// ---------------------------------------------------------------------------
module tb_top;
   import rfla_pkg::*;

   localparam int NumRanges = 16;
   localparam logic [31:0] TopValue = 32'hFFFF_FFFF;
   localparam int IdleLimit = 20000;
   localparam logic ReqFree = 1'b0;
   localparam logic ReqAlloc = 1'b1;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [31:0] req_range_from = '0;
   logic [31:0] req_range_to = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [31:0] rsp_alloc_value;

   // model of the free table
   logic [31:0] mdl_lo [NumRanges];
   logic [31:0] mdl_hi [NumRanges];
   int mdl_count = 0;

   outcome_type pending_q[$];
   int fail_count = 0;
   int idle_cycles = 0;
   int hold_off = 0;
   bit lazy_rx = 1'b0;

   range_free_list_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_range_from(req_range_from), .req_range_to(req_range_to),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_alloc_value(rsp_alloc_value)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // remove one table entry, closing the gap
   function automatic void mdl_drop(int idx);
      for (int k = idx; k + 1 < mdl_count; k++) begin
         mdl_lo[k] = mdl_lo[k+1];
         mdl_hi[k] = mdl_hi[k+1];
      end
      mdl_count--;
   endfunction

   function automatic outcome_type predict_request(logic kind, logic [31:0] lo,
                                                   logic [31:0] hi);
      outcome_type res;
      int pos;
      bit jp, jn;
      res = '{status: ST_OK, value: '0};
      if (kind == ReqAlloc) begin
         if (mdl_count == 0) res.status = ST_EMPTY;
         else begin
            res.value = mdl_lo[0];
            if (mdl_lo[0] == mdl_hi[0]) mdl_drop(0);
            else mdl_lo[0] = mdl_lo[0] + 1;
         end
         return res;
      end
      if (lo > hi) begin
         res.status = ST_INVERTED;
         return res;
      end
      for (int i = 0; i < mdl_count; i++)
         if (lo <= mdl_hi[i] && hi >= mdl_lo[i]) begin
            res.status = ST_OVERLAP;
            return res;
         end
      pos = 0;
      while (pos < mdl_count && mdl_lo[pos] < lo) pos++;
      jp = pos > 0 && lo != 0 && mdl_hi[pos-1] == lo - 1;
      jn = pos < mdl_count && hi != TopValue && mdl_lo[pos] == hi + 1;
      if (jp && jn) begin
         mdl_hi[pos-1] = mdl_hi[pos];
         mdl_drop(pos);
      end else if (jp) begin
         mdl_hi[pos-1] = hi;
      end else if (jn) begin
         mdl_lo[pos] = lo;
      end else if (mdl_count >= NumRanges) begin
         res.status = ST_FULL;
      end else begin
         for (int k = mdl_count; k > pos; k--) begin
            mdl_lo[k] = mdl_lo[k-1];
            mdl_hi[k] = mdl_hi[k-1];
         end
         mdl_lo[pos] = lo;
         mdl_hi[pos] = hi;
         mdl_count++;
      end
      return res;
   endfunction

   // offer one request, predict it on acceptance; valid stays up afterwards
   // so that a following request without a gap needs no second drive
   task automatic send_request(logic kind, logic [31:0] lo, logic [31:0] hi,
                               bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_range_from <= lo;
      req_range_to <= hi;
      do @(posedge clock); while (!req_ready);
      pending_q.push_back(predict_request(kind, lo, hi));
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   // receiver: random wait after each response when lazy_rx is set, or a long hold-off
   initial begin
      int wait_n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            hold_off--;
         end else if (rsp_valid && rsp_ready) begin
            wait_n = lazy_rx ? $urandom_range(0, 17) : 0;
            if (wait_n > 0) begin
               rsp_ready <= 1'b0;
               repeat (wait_n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // response check against oldest prediction
   always @(posedge clock) begin
      outcome_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response status %0d value %h",
                     $time, rsp_status, rsp_alloc_value);
            fail_count++;
         end else begin
            exp_r = pending_q.pop_front();
            if (rsp_status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_alloc_value !== exp_r.value) begin
               $display("%0t: alloc value expected %h actual %h",
                        $time, exp_r.value, rsp_alloc_value);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_edges;
      send_request(ReqAlloc, 32'h0, 32'h0);
      send_request(ReqFree, 32'h10, 32'h5);
      send_request(ReqFree, 32'h0, 32'h0);
      send_request(ReqFree, TopValue, TopValue);
      send_request(ReqFree, 32'h1, 32'h1);
      send_request(ReqFree, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
      send_request(ReqFree, 32'h20, 32'h2F);
      send_request(ReqFree, 32'h40, 32'h4F);
      send_request(ReqFree, 32'h30, 32'h3F);
      send_request(ReqFree, 32'h10, 32'h60);
      send_request(ReqFree, 32'h25, 32'h25);
      send_request(ReqFree, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
      send_request(ReqAlloc, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ReqAlloc, 32'h0, 32'h0);
      drain();
   endtask

   // fill the table with isolated ranges, then beyond
   task automatic test_full_table;
      for (int i = 0; i < NumRanges + 2; i++)
         send_request(ReqFree, 32'(32'h1000_0000 + i * 4),
                      32'(32'h1000_0000 + i * 4 + 1));
      for (int i = 0; i < NumRanges + 4; i++)
         send_request(ReqAlloc, $urandom, $urandom);
      drain();
   endtask

   task automatic test_backpressure;
      hold_off = 300;
      for (int i = 0; i < 12; i++)
         send_request(i % 3 ? ReqAlloc : ReqFree, 32'(i * 7 + 100), 32'(i * 7 + 102), 1);
      drain();
   endtask

   task automatic test_random(int count);
      logic [31:0] lo, hi, base;
      int sel;
      lazy_rx = 1'b1;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 9);
         base = mdl_count ? mdl_hi[$urandom_range(0, mdl_count - 1)] : $urandom;
         if (sel < 3) begin
            send_request(ReqAlloc, $urandom, $urandom);
         end else if (sel < 7) begin
            lo = base + $urandom_range(1, 3);
            hi = lo + $urandom_range(0, 5);
            send_request(ReqFree, lo, hi);
         end else if (sel < 9) begin
            lo = $urandom;
            hi = $urandom_range(0, 1) ? lo + $urandom_range(0, 64) : $urandom;
            send_request(ReqFree, lo, hi);
         end else begin
            send_request(ReqFree, $urandom_range(0, 1) ? 32'h0 : TopValue - 3,
                         $urandom_range(0, 1) ? TopValue : 32'h3);
         end
         if (n % 200 == 199) drain();
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_full_table();
      test_backpressure();
      test_random(1340);
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending_q.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
